@@ hw/rtl/smia_pkg.sv @@
// Package for the stack machine integer ALU.
// Holds operation codes, shared widths and the pipeline token types.
package smia_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned KindW    = 4;
  localparam int unsigned DivSteps = DataW;

  localparam logic [KindW-1:0] KindAdd  = 4'd0;
  localparam logic [KindW-1:0] KindSub  = 4'd1;
  localparam logic [KindW-1:0] KindMul  = 4'd2;
  localparam logic [KindW-1:0] KindDiv  = 4'd3;
  localparam logic [KindW-1:0] KindRem  = 4'd4;
  localparam logic [KindW-1:0] KindNeg  = 4'd5;
  localparam logic [KindW-1:0] KindShl  = 4'd6;
  localparam logic [KindW-1:0] KindShr  = 4'd7;
  localparam logic [KindW-1:0] KindUshr = 4'd8;
  localparam logic [KindW-1:0] KindAnd  = 4'd9;
  localparam logic [KindW-1:0] KindOr   = 4'd10;
  localparam logic [KindW-1:0] KindXor  = 4'd11;

  // Token leaving the front stage: partial products still unsummed
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             is_long;
    logic             dz;
    logic             neg_q;
    logic             neg_r;
    logic [DataW-1:0] res;
    logic [DataW-1:0] pp_ll;
    logic [HalfW-1:0] pp_lh;
    logic [HalfW-1:0] pp_hl;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
  } front_t;

  // Token travelling through the divider steps
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             is_long;
    logic             dz;
    logic             neg_q;
    logic             neg_r;
    logic [DataW-1:0] res;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] dvs;
  } div_t;

  function automatic logic [DataW-1:0] sext32(input logic [DataW-1:0] v);
    return {{HalfW{v[HalfW-1]}}, v[HalfW-1:0]};
  endfunction

endpackage

@@ hw/rtl/smia_front.sv @@
// Front stage: operand sign extension, simple ops, partial products, divide setup.
// Depends on smia_pkg.
module smia_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  logic                                  valid_i,
  input  logic [smia_pkg::KindW-1:0]            kind_i,
  input  logic                                  is_long_i,
  input  logic [smia_pkg::DataW-1:0]            a_i,
  input  logic [smia_pkg::DataW-1:0]            b_i,
  output logic                                  valid_o,
  output smia_pkg::front_t                      tok_o
);

  logic [smia_pkg::DataW-1:0] a_x, b_x, res;
  logic [5:0]                 sh;
  logic                       is_dr;
  smia_pkg::front_t           tok_d, tok_q;
  logic                       valid_q;

  assign a_x   = is_long_i ? a_i : smia_pkg::sext32(a_i);
  assign b_x   = is_long_i ? b_i : smia_pkg::sext32(b_i);
  assign sh    = is_long_i ? b_x[5:0] : {1'b0, b_x[4:0]};
  assign is_dr = (kind_i == smia_pkg::KindDiv) || (kind_i == smia_pkg::KindRem);

  // simple operations: add, sub, neg, shifts, logic
  always_comb begin
    case (kind_i)
      smia_pkg::KindAdd: res = a_x + b_x;
      smia_pkg::KindSub: res = a_x - b_x;
      smia_pkg::KindNeg: res = '0 - a_x;
      smia_pkg::KindShl: res = a_x << sh;
      smia_pkg::KindShr: res = $unsigned($signed(a_x) >>> sh);
      smia_pkg::KindUshr: res = is_long_i ? (a_x >> sh)
                                          : ({{smia_pkg::HalfW{1'b0}},
                                              a_x[smia_pkg::HalfW-1:0]} >> sh);
      smia_pkg::KindAnd: res = a_x & b_x;
      smia_pkg::KindOr:  res = a_x | b_x;
      smia_pkg::KindXor: res = a_x ^ b_x;
      default:           res = '0;
    endcase
  end

  // token for the next stage
  always_comb begin
    tok_d.kind    = kind_i;
    tok_d.is_long = is_long_i;
    tok_d.dz      = is_dr && (b_x == '0);
    tok_d.neg_q   = a_x[smia_pkg::DataW-1] ^ b_x[smia_pkg::DataW-1];
    tok_d.neg_r   = a_x[smia_pkg::DataW-1];
    tok_d.res     = res;
    tok_d.pp_ll   = a_x[smia_pkg::HalfW-1:0] * b_x[smia_pkg::HalfW-1:0];
    tok_d.pp_lh   = smia_pkg::HalfW'(a_x[smia_pkg::HalfW-1:0]
                                     * b_x[smia_pkg::DataW-1:smia_pkg::HalfW]);
    tok_d.pp_hl   = smia_pkg::HalfW'(a_x[smia_pkg::DataW-1:smia_pkg::HalfW]
                                     * b_x[smia_pkg::HalfW-1:0]);
    tok_d.ma      = a_x[smia_pkg::DataW-1] ? ('0 - a_x) : a_x;
    tok_d.mb      = b_x[smia_pkg::DataW-1] ? ('0 - b_x) : b_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

@@ hw/rtl/smia_div_step.sv @@
// One restoring-division step: one quotient bit per stage.
// Depends on smia_pkg.
module smia_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  smia_pkg::div_t tok_i,
  output logic           valid_o,
  output smia_pkg::div_t tok_o
);

  logic [smia_pkg::DataW:0] t, diff;
  logic                     ge;
  smia_pkg::div_t           tok_d, tok_q;
  logic                     valid_q;

  // shift in next dividend bit, trial subtract
  assign t    = {tok_i.rem, tok_i.quo[smia_pkg::DataW-1]};
  assign diff = t - {1'b0, tok_i.dvs};
  assign ge   = !diff[smia_pkg::DataW];

  always_comb begin
    tok_d     = tok_i;
    tok_d.rem = ge ? diff[smia_pkg::DataW-1:0] : t[smia_pkg::DataW-1:0];
    tok_d.quo = {tok_i.quo[smia_pkg::DataW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

@@ hw/rtl/stack_machine_integer_alu.sv @@
// Pipeline of 67 register stages: front, multiply sum, 64 divide steps, output.
// Throughput: one item per cycle while the output is not stalled; the 64-stage
// restoring divider is fully pipelined. The whole pipeline advances together when the
// output is empty or taken. Reset clears all valid bits; payload registers are not reset.
// Top level of the stack machine integer ALU. Depends on smia_pkg, smia_front,
// smia_div_step.
module stack_machine_integer_alu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [smia_pkg::KindW-1:0]         kind_i,
  input  logic                               is_long_i,
  input  logic signed [smia_pkg::DataW-1:0]  left_operand_i,
  input  logic signed [smia_pkg::DataW-1:0]  right_operand_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [smia_pkg::DataW-1:0]  result_o,
  output logic                               divide_by_zero_o
);

  logic                         adv;
  logic                         f_valid;
  smia_pkg::front_t             f_tok;
  logic                         m_valid_q;
  smia_pkg::div_t               m_tok_d, m_tok_q;
  logic [smia_pkg::DivSteps:0]  s_valid;
  smia_pkg::div_t               s_tok [smia_pkg::DivSteps+1];
  smia_pkg::div_t               z;
  logic [smia_pkg::DataW-1:0]   fin;
  logic                         out_valid_q;
  logic [smia_pkg::DataW-1:0]   result_q;
  logic                         dz_q;

  // global advance: output register free or being taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  smia_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_valid_i),
    .kind_i   (kind_i),
    .is_long_i(is_long_i),
    .a_i      ($unsigned(left_operand_i)),
    .b_i      ($unsigned(right_operand_i)),
    .valid_o  (f_valid),
    .tok_o    (f_tok)
  );

  // multiply sum and divider setup
  always_comb begin
    m_tok_d.kind    = f_tok.kind;
    m_tok_d.is_long = f_tok.is_long;
    m_tok_d.dz      = f_tok.dz;
    m_tok_d.neg_q   = f_tok.neg_q;
    m_tok_d.neg_r   = f_tok.neg_r;
    m_tok_d.res     = (f_tok.kind == smia_pkg::KindMul)
                      ? f_tok.pp_ll + {f_tok.pp_lh + f_tok.pp_hl, {smia_pkg::HalfW{1'b0}}}
                      : f_tok.res;
    m_tok_d.quo     = f_tok.ma;
    m_tok_d.rem     = '0;
    m_tok_d.dvs     = f_tok.mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_tok_q <= m_tok_d;
    end
  end

  assign s_valid[0] = m_valid_q;
  assign s_tok[0]   = m_tok_q;

  // divider pipeline
  for (genvar i = 0; i < smia_pkg::DivSteps; i++) begin : g_div
    smia_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(s_valid[i]),
      .tok_i  (s_tok[i]),
      .valid_o(s_valid[i+1]),
      .tok_o  (s_tok[i+1])
    );
  end

  // sign fix, result select, int sign extension
  assign z = s_tok[smia_pkg::DivSteps];
  always_comb begin
    case (z.kind)
      smia_pkg::KindDiv: fin = z.dz ? '0 : (z.neg_q ? ('0 - z.quo) : z.quo);
      smia_pkg::KindRem: fin = z.dz ? '0 : (z.neg_r ? ('0 - z.rem) : z.rem);
      default:           fin = z.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s_valid[smia_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= z.is_long ? fin : smia_pkg::sext32(fin);
      dz_q     <= z.dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = $signed(result_q);
  assign divide_by_zero_o = dz_q;

  // flagged divide always returns zero
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_q == '0)
    else $error("divide by zero with nonzero result");

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_q))
    else $error("stalled result lost or changed");

  // input stalls exactly when the output is blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output stall");

  // front token moves into the divider input register on an advance
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && f_valid |=> m_valid_q)
    else $error("token lost between front and divider");

endmodule
